### src/s2da_pkg.sv
// shared types and constants for the signed integer to decimal text converter
package s2da_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);

  localparam logic [7:0]  ASCII_ZERO  = 8'd48;
  localparam logic [7:0]  ASCII_MINUS = 8'd45;
  localparam logic [7:0]  ASCII_NINE  = 8'd57;

  // floor(x / 10) == (x * RECIP_DIV10) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP_DIV10 = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef logic [3:0] digit_t;

  // one converted number, digits stored least significant first
  typedef struct packed {
    logic                        neg;
    logic [DIG_CNT_W-1:0]        ndig;
    digit_t [MAX_DIGITS-1:0]     digits;
  } num_entry_t;

endpackage

### src/s2da_front.sv
// front end: takes a number, splits off the sign and peels decimal digits
module s2da_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic signed [31:0]      value,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    q_full,
  output logic                    q_push,
  output s2da_pkg::num_entry_t    q_entry
);
  import s2da_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t            state;
  logic                    neg;
  logic [31:0]             mag;
  logic [DIG_CNT_W-1:0]    ndig;
  digit_t [MAX_DIGITS-1:0] digits;

  logic [31:0] raw;
  logic [31:0] mag_in;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] quot10;
  logic [31:0] rem;
  logic        accept;
  logic        conv_done;

  assign raw    = value;
  assign mag_in = raw[31] ? (32'd0 - raw) : raw;

  // divide by ten through the reciprocal, remainder by shift-add
  assign prod   = 64'(mag) * 64'(RECIP_DIV10);
  assign quot   = 32'(prod >> RECIP_SHIFT);
  assign quot10 = (quot << 3) + (quot << 1);
  assign rem    = mag - quot10;

  assign conv_done = (quot == 32'd0) || (ndig == DIG_CNT_W'(MAX_DIGITS - 1));

  assign q_push   = (state == F_PUSH) && !q_full;
  assign in_stall = (state == F_CONV) || ((state == F_PUSH) && q_full);
  assign accept   = in_valid && !in_stall;

  assign q_entry.neg    = neg;
  assign q_entry.ndig   = ndig;
  assign q_entry.digits = digits;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) state <= F_CONV;
        end
        F_CONV: begin
          if (conv_done) state <= F_PUSH;
        end
        F_PUSH: begin
          if (q_push) state <= accept ? F_CONV : F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg  <= raw[31];
      mag  <= mag_in;
      ndig <= '0;
    end else if (state == F_CONV) begin
      digits[ndig[DIG_IDX_W-1:0]] <= rem[3:0];
      ndig                        <= ndig + DIG_CNT_W'(1);
      mag                         <= quot;
    end
  end

endmodule

### src/s2da_queue.sv
// short queue of converted numbers between front and back
module s2da_queue #(
  parameter int DEPTH = s2da_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  s2da_pkg::num_entry_t  push_entry,
  input  logic                  pop,
  output s2da_pkg::num_entry_t  head,
  output logic                  empty,
  output logic                  full
);
  import s2da_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  num_entry_t         slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule

### src/s2da_back.sv
// back end: walks one queued number out as characters, most significant first
module s2da_back (
  input  logic                  clk,
  input  logic                  rst,
  input  s2da_pkg::num_entry_t  q_head,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic [7:0]            char_code,
  output logic                  last_char,
  output logic                  out_valid,
  input  logic                  out_stall
);
  import s2da_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_SIGN  = 3'b010,
    B_DIGIT = 3'b100
  } back_state_t;

  back_state_t             state;
  digit_t [MAX_DIGITS-1:0] digits;
  logic [DIG_IDX_W-1:0]    idx;

  logic       slot_free;
  logic       emit;
  logic [7:0] cur_char;
  logic       cur_last;

  assign slot_free = !out_valid || !out_stall;
  assign emit      = (state != B_IDLE) && slot_free;
  assign cur_char  = (state == B_SIGN) ? ASCII_MINUS : ASCII_ZERO + {4'd0, digits[idx]};
  assign cur_last  = (state == B_DIGIT) && (idx == '0);
  assign q_pop     = !q_empty && ((state == B_IDLE) || (emit && cur_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (slot_free) out_valid <= emit;
      if (q_pop) begin
        state <= q_head.neg ? B_SIGN : B_DIGIT;
      end else if (emit) begin
        unique case (state)
          B_SIGN:  state <= B_DIGIT;
          B_DIGIT: if (cur_last) state <= B_IDLE;
          default: state <= B_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_code <= cur_char;
      last_char <= cur_last;
      if (state == B_DIGIT && idx != '0) idx <= idx - DIG_IDX_W'(1);
    end
    if (q_pop) begin
      digits <= q_head.digits;
      idx    <= DIG_IDX_W'(q_head.ndig - DIG_CNT_W'(1));
    end
  end

endmodule

### src/signed_int_to_decimal_ascii.sv
// top level of the signed 32-bit integer to decimal ascii converter
// Converts each signed 32-bit number taken on the input channel into its
// decimal text, one ascii character per output transfer, most significant
// digit first, with a leading '-' for negative numbers and last_char set on
// the final digit; zero gives a single '0' and -2147483648 comes out in
// full. The front end peels one digit per cycle with a 32x32 reciprocal
// multiply (divide by ten), then holds the number in a push state until
// the queue takes it; the back end sends one character per cycle while
// out_stall is low. The two are joined by a short queue, so the sustained
// rate is set by the front end's digit loop and, for negative numbers
// equally, by the character count on the output channel (eleven for the
// longest negative numbers). Nothing is kept between numbers and there is
// no set-up.
module signed_int_to_decimal_ascii #(
  parameter int QUEUE_DEPTH = s2da_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] value,
  input  logic               in_valid,
  output logic               in_stall,
  output logic [7:0]         char_code,
  output logic               last_char,
  output logic               out_valid,
  input  logic               out_stall
);
  import s2da_pkg::*;

  // queue handshake between the two halves
  num_entry_t push_entry;
  num_entry_t head;
  logic       q_push;
  logic       q_pop;
  logic       q_empty;
  logic       q_full;

  // sign split and digit extraction
  s2da_front u_front (
    .clk      (clk),
    .rst      (rst),
    .value    (value),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  // decouples digit extraction from character output
  s2da_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // character sequencer with registered output
  s2da_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .char_code (char_code),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

`ifndef ASSERT_OFF
  // the front end never writes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue written while full");

  // the back end never takes from an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue read while empty");

  // a sign is always followed by at least one digit
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && char_code == ASCII_MINUS) |-> !last_char)
    else $error("minus sign flagged as last character");

  // only a sign or a decimal digit ever leaves
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == ASCII_MINUS ||
                   (char_code >= ASCII_ZERO && char_code <= ASCII_NINE)))
    else $error("character outside sign and digit set");
`endif

endmodule
